>>> rtl/sorted_list_insert_delete_top_defines.svh
// ---------------------------------------------------------------------------
// Sorted list assertion macros
// Shared assertion forms for the sorted list block: a same-cycle implication
// and a next-cycle implication, both held off during reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list: next-cycle check failed");

`endif

>>> rtl/sli_pkg.sv
// ---------------------------------------------------------------------------
// Sorted list package
// Widths, codes and the structures that pass between the top level and the
// row of storage cells.
// ---------------------------------------------------------------------------
package sli_pkg;

  localparam int KEY_W        = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  // Handed from each cell to its right-hand neighbour.
  typedef struct packed {
    logic                    lt;
    logic signed [KEY_W-1:0] val;
  } link_t;

endpackage

>>> rtl/sli_cell.sv
// ---------------------------------------------------------------------------
// Sorted list cell
// One place of the list: holds a key, compares it with the broadcast key and
// takes its new key from itself, the broadcast key or a neighbour.
// ---------------------------------------------------------------------------
module sli_cell (
  input  logic                           clk,
  input  sli_pkg::cmd_t                  cmd,
  input  logic                           occ,
  input  sli_pkg::link_t                 from_left,
  input  logic signed [sli_pkg::KEY_W-1:0] from_right,
  output sli_pkg::link_t                 to_right,
  output logic                           found_here,
  output logic signed [sli_pkg::KEY_W-1:0] val_next
);

  logic signed [sli_pkg::KEY_W-1:0] val;
  logic                             lt;
  logic                             at_pos;

  // The list is ascending, so the cells that hold smaller keys form a prefix;
  // the first cell outside it is the insertion point.
  assign lt     = occ && (val < cmd.key);
  assign at_pos = from_left.lt && !lt;

  assign found_here = at_pos && occ && (val == cmd.key);

  always_comb begin
    priority if (cmd.ins_en && !lt) begin
      val_next = at_pos ? cmd.key : from_left.val;
    end else if (cmd.del_en && !lt) begin
      val_next = from_right;
    end else begin
      val_next = val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign to_right.lt  = lt;
  assign to_right.val = val;

endmodule

>>> rtl/sorted_list_insert_delete_top.sv
// ---------------------------------------------------------------------------
// Sorted list top level
// Bounded ascending list of signed keys with insert and delete, built as a
// row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// The block takes one beat per clock cycle unless its output is held off, and
// returns one result beat in the cycle after it is accepted. Every cell
// compares the broadcast key with its own entry in parallel; the cells from
// the insert or delete point on shift one place at once, whatever the length.
// The output register lets a new beat enter in the same cycle as the previous
// result leaves; while a result is held off, the input stalls.
// Inserts go before the first entry not smaller than the key, deletes remove
// the first equal entry. Count is reported in its low five bits.
`include "sorted_list_insert_delete_top_defines.svh"

module sorted_list_insert_delete_top #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic signed [sli_pkg::KEY_W-1:0]     value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [sli_pkg::COUNT_OUT_W-1:0]      count,
  output logic signed [sli_pkg::KEY_W-1:0]     smallest,
  output logic                                 nonempty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                 held;
  logic [CNT_W-1:0]                 held_next;
  logic                             in_acc;
  logic                             is_ins;
  logic                             full;
  logic                             found;
  sli_pkg::cmd_t                    cmd;
  sli_pkg::status_t                 st;
  logic [CAPACITY-1:0]              occ;
  logic [CAPACITY-1:0]              found_vec;
  sli_pkg::link_t                   link [CAPACITY+1];
  logic signed [sli_pkg::KEY_W-1:0] cell_next [CAPACITY];
  logic [CNT_W+sli_pkg::COUNT_OUT_W-1:0] held_wide;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign is_ins   = (opcode == sli_pkg::OP_INSERT);
  assign full     = (held == CNT_W'(CAPACITY));
  assign found    = |found_vec;

  assign cmd.key    = value;
  assign cmd.ins_en = in_acc && is_ins && !full;
  assign cmd.del_en = in_acc && !is_ins && found;

  // Left boundary: everything before the first cell counts as smaller.
  assign link[0].lt  = 1'b1;
  assign link[0].val = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic signed [sli_pkg::KEY_W-1:0] right_val;

    assign occ[i] = (held > IDX);

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = link[i+2].val;
    end

    sli_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .from_left  (link[i]),
      .from_right (right_val),
      .to_right   (link[i+1]),
      .found_here (found_vec[i]),
      .val_next   (cell_next[i])
    );
  end

  always_comb begin
    held_next = held;
    if (cmd.ins_en) begin
      held_next = held + CNT_W'(1);
    end else if (cmd.del_en) begin
      held_next = held - CNT_W'(1);
    end
  end

  always_comb begin
    unique case ({is_ins, full, found})
      3'b110, 3'b111: st = sli_pkg::ST_FULL;
      3'b100, 3'b101: st = sli_pkg::ST_INSERTED;
      3'b001, 3'b011: st = sli_pkg::ST_DELETED;
      default:        st = sli_pkg::ST_NOT_FOUND;
    endcase
  end

  assign held_wide = {{sli_pkg::COUNT_OUT_W{1'b0}}, held_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      held <= held_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status   <= st;
      count    <= held_wide[sli_pkg::COUNT_OUT_W-1:0];
      smallest <= (held_next != '0) ? cell_next[0] : '0;
      nonempty <= (held_next != '0);
    end
  end

  // At most one cell can be the first equal entry.
  `SLI_ASSERT_IMPL(a_found_unique, clk, rst, 1'b1, $onehot0(found_vec))
  // An insert into a list with room grows it by exactly one.
  `SLI_ASSERT_NEXT(a_ins_grows, clk, rst, cmd.ins_en, held == $past(held) + CNT_W'(1))
  // A successful delete shrinks the list by exactly one.
  `SLI_ASSERT_NEXT(a_del_shrinks, clk, rst, cmd.del_en, held == $past(held) - CNT_W'(1))
  // The two front entries stay in ascending order.
  `SLI_ASSERT_IMPL(a_front_sorted, clk, rst, occ[1], link[1].val <= link[2].val)
  // Every accepted beat leaves a result waiting.
  `SLI_ASSERT_NEXT(a_result_follows, clk, rst, in_acc, out_valid)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted list insert/delete testbench
// Drives insert and delete beats into the sorted list with random idling on
// both sides, keeps its own ordered copy of the list to predict each result
// beat, and compares status, count, smallest entry and non-empty flag.
// ---------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH = sli_pkg::CAPACITY_DEF;

  typedef struct {
    sli_pkg::status_t                       status;
    logic [sli_pkg::COUNT_OUT_W-1:0]        count;
    logic signed [sli_pkg::KEY_W-1:0]       smallest;
    logic                                   nonempty;
  } list_result_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   in_valid;
  logic                                   in_stall;
  logic                                   opcode;
  logic signed [sli_pkg::KEY_W-1:0]       value;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [1:0]                             status;
  logic [sli_pkg::COUNT_OUT_W-1:0]        count;
  logic signed [sli_pkg::KEY_W-1:0]       smallest;
  logic                                   nonempty;

  // Ordered copy of the list and the results still owed by the block.
  logic signed [sli_pkg::KEY_W-1:0] sorted_keys[$];
  list_result_t                     pending_results[$];
  list_result_t                     owed;

  int error_count = 0;
  int results_checked = 0;
  int inserts_done = 0;
  int inserts_refused = 0;
  int deletes_done = 0;
  int deletes_missed = 0;
  int peak_held = 0;

  // Idling controls for the sender and the receiver.
  int gap_pct = 0;
  int stall_pct = 0;
  int holdoff_request = 0;
  int stall_left = 0;

  sorted_list_insert_delete_top #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count     (count),
    .smallest  (smallest),
    .nonempty  (nonempty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Most gaps are short, the odd one is long.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic list_result_t apply_list_op(sli_pkg::opcode_t op,
                                                 logic signed [sli_pkg::KEY_W-1:0] key);
    list_result_t r;
    int           pos;
    pos = 0;
    if (op == sli_pkg::OP_INSERT) begin
      if (sorted_keys.size() >= LIST_DEPTH) begin
        r.status = sli_pkg::ST_FULL;
        inserts_refused++;
      end else begin
        while (pos < sorted_keys.size() && sorted_keys[pos] < key) pos++;
        sorted_keys.insert(pos, key);
        r.status = sli_pkg::ST_INSERTED;
        inserts_done++;
      end
    end else begin
      while (pos < sorted_keys.size() && sorted_keys[pos] != key) pos++;
      if (pos >= sorted_keys.size()) begin
        r.status = sli_pkg::ST_NOT_FOUND;
        deletes_missed++;
      end else begin
        sorted_keys.delete(pos);
        r.status = sli_pkg::ST_DELETED;
        deletes_done++;
      end
    end
    if (sorted_keys.size() > peak_held) peak_held = sorted_keys.size();
    r.count    = sli_pkg::COUNT_OUT_W'(sorted_keys.size());
    r.nonempty = (sorted_keys.size() > 0);
    r.smallest = (sorted_keys.size() > 0) ? sorted_keys[0] : '0;
    return r;
  endfunction

  // Predicts on every accepted input beat and checks every accepted result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_list_op(sli_pkg::opcode_t'(opcode), value));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding: status=%0d count=%0d", status, count);
          error_count++;
        end else begin
          owed = pending_results.pop_front();
          results_checked++;
          if (status !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, status);
            error_count++;
          end
          if (count !== owed.count) begin
            $error("count: expected %0d, got %0d", owed.count, count);
            error_count++;
          end
          if (smallest !== owed.smallest) begin
            $error("smallest: expected %0d, got %0d", owed.smallest, smallest);
            error_count++;
          end
          if (nonempty !== owed.nonempty) begin
            $error("nonempty: expected %0d, got %0d", owed.nonempty, nonempty);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when the pressure test asks.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request > 0) begin
        stall_left = holdoff_request;
        holdoff_request = 0;
      end else if (stall_left == 0 && $urandom_range(1, 100) <= stall_pct) begin
        stall_left = idle_len();
      end
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input sli_pkg::opcode_t op,
                           input logic signed [sli_pkg::KEY_W-1:0] key);
    int gap;
    if ($urandom_range(1, 100) <= gap_pct) begin
      gap = idle_len();
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode   = op;
    value    = key;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid = 1'b0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      error_count++;
      pending_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [sli_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_beat(sli_pkg::OP_DELETE, 0);
    send_beat(sli_pkg::OP_DELETE, 32'sh8000_0000);
    send_beat(sli_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    send_beat(sli_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_beat(sli_pkg::OP_INSERT, 32'sh8000_0000);
    send_beat(sli_pkg::OP_INSERT, 0);
    send_beat(sli_pkg::OP_INSERT, -1);
    send_beat(sli_pkg::OP_INSERT, 1);
    send_beat(sli_pkg::OP_INSERT, 1);
    send_beat(sli_pkg::OP_DELETE, 1);
    send_beat(sli_pkg::OP_DELETE, 32'sh8000_0000);
    send_beat(sli_pkg::OP_DELETE, 7);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    while (sorted_keys.size() < LIST_DEPTH) begin
      send_beat(sli_pkg::OP_INSERT, $signed($urandom_range(0, 40)) - 20);
    end
    send_beat(sli_pkg::OP_INSERT, 32'sh8000_0000);
    send_beat(sli_pkg::OP_INSERT, 5);
    send_beat(sli_pkg::OP_DELETE, 32'sh1234_5678);
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    holdoff_request = 60;
    repeat (30) begin
      send_beat(($urandom_range(0, 1) != 0) ? sli_pkg::OP_DELETE : sli_pkg::OP_INSERT,
                rand_key());
    end
    wait_drained();
  endtask

  task automatic test_random_mix();
    int round;
    int insert_pct;
    int idx;
    for (round = 0; round < 20; round++) begin
      case (round % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      if (round % 4 == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      repeat (50) begin
        if ($urandom_range(1, 100) <= insert_pct) begin
          send_beat(sli_pkg::OP_INSERT, rand_key());
        end else if (sorted_keys.size() > 0 && $urandom_range(0, 9) < 6) begin
          idx = $urandom_range(0, sorted_keys.size() - 1);
          send_beat(sli_pkg::OP_DELETE, sorted_keys[idx]);
        end else begin
          send_beat(sli_pkg::OP_DELETE, rand_key());
        end
      end
    end
    gap_pct = 0;
    stall_pct = 0;
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = sli_pkg::OP_INSERT;
    value    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_key_extremes();
    test_fill_to_full();
    test_backpressure();
    test_random_mix();

    $display("Checked %0d results: %0d inserts, %0d refused as full, %0d deletes, %0d misses.",
             results_checked, inserts_done, inserts_refused, deletes_done, deletes_missed);
    $display("The list reached %0d of %0d entries.", peak_held, LIST_DEPTH);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sorted_list_insert_delete_top.f
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete_top.sv
tb/testbench.sv
